/* sv/sorted_insert_priority_queue_assert.svh */
// Assertion macros shared by the priority queue checker.
// Depends on signals clk and arst_n in the scope where a macro is used.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SIPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define SIPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sipq_pkg.sv */
// Package for the sorted insert priority queue: sizes, codes, payload types.
// No dependencies.
package sipq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 8;

	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VALUE_W = 32;
	localparam int ENTRY_W = VALUE_W + PRIO_BITS;

	// command codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                      cmd;
		logic signed [VALUE_W-1:0] item_value;
		logic [7:0]                item_priority;
	} req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] removed_value;
		logic [7:0]                removed_priority;
		logic [4:0]                entry_count;
	} rsp_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_BITS-1:0]      prio;
	} entry_t;

endpackage

/* sv/sipq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sipq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/sorted_insert_priority_queue.sv */
// Top level of the sorted insert priority queue, entries in one RAM.
// Depends on sipq_pkg and sipq_ram.
//
//  channel | signals                      | moves
//  --------+------------------------------+-------------------------------
//  req     | req_valid, req_ready, req    | one enqueue or dequeue command
//  rsp     | rsp_valid, rsp_ready, rsp    | one result per command
//
// Enqueue moves k entries back one slot (k < DEPTH) in S_SCAN, during the
// read-modify-write walk through the single entry RAM, then writes the new entry
// in S_SCAN or S_PLACE and goes to S_HOLD. Enqueue into an empty queue, and a
// rejected command, go from S_IDLE straight to S_HOLD; dequeue passes S_DEQ.
// Reset clears state, head, count and output valid; RAM is not reset, only written entries are used.
// A result waits in the output register while the next command is taken;
// if it is still stalled, the next result holds in S_HOLD with req_ready low.
module sorted_insert_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sipq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sipq_pkg::rsp_t rsp
);
	import sipq_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_PLACE = 3'd2;
	localparam logic [2:0] S_DEQ   = 3'd3;
	localparam logic [2:0] S_HOLD  = 3'd4;

	logic [2:0]           state_q, state_n;
	logic [IDX_W-1:0]     head_q, head_n;
	logic [CNT_W-1:0]     occ_q, occ_n;
	logic [IDX_W-1:0]     pos_q, pos_n;
	logic [VALUE_W-1:0]   val_q, val_n;
	logic [PRIO_BITS-1:0] pri_q, pri_n;
	rsp_t                 res_q, res_n;
	rsp_t                 out_q;
	logic                 out_valid_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr, ram_raddr;
	entry_t               ram_wdata, ram_rdata;
	logic [ENTRY_W-1:0]   ram_rdata_bits;

	logic                 req_xfer, full, empty, out_free;
	logic [IDX_W-1:0]     pos_m1, pos_m2, occ_idx;
	logic [PRIO_BITS-1:0] req_pri;

	// slot of an offset from the head, wrapped at DEPTH
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IDX_W + 1)'(DEPTH)) begin
			s = s - (IDX_W + 1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	sipq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata_bits)
	);
	assign ram_rdata = entry_t'(ram_rdata_bits);

	assign req_ready = (state_q == S_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign full      = (occ_q == CNT_W'(DEPTH));
	assign empty     = (occ_q == '0);
	assign out_free  = !out_valid_q || rsp_ready;
	assign occ_idx   = occ_q[IDX_W-1:0];
	assign pos_m1    = pos_q - 1'b1;
	assign pos_m2    = pos_m1 - 1'b1;
	assign req_pri   = PRIO_BITS'(req.item_priority);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// command sequencer
	always_comb begin
		state_n   = state_q;
		head_n    = head_q;
		occ_n     = occ_q;
		pos_n     = pos_q;
		val_n     = val_q;
		pri_n     = pri_q;
		res_n     = res_q;
		ram_we    = 1'b0;
		ram_waddr = slot_of(head_q, pos_q);
		ram_wdata = '{value: val_q, prio: pri_q};
		ram_raddr = slot_of(head_q, pos_m2);

		unique case (state_q)
			S_IDLE: begin
				val_n = req.item_value;
				pri_n = req_pri;
				pos_n = occ_idx;
				if (req.cmd == CMD_ENQ) begin
					ram_raddr = slot_of(head_q, occ_idx - 1'b1);
				end else begin
					ram_raddr = head_q;
				end
				if (req_xfer) begin
					res_n = '{status: ST_DONE, removed_value: '0,
						removed_priority: '0, entry_count: 5'(occ_q)};
					if (req.cmd == CMD_ENQ) begin
						if (full) begin
							res_n.status = ST_FULL;
							state_n      = S_HOLD;
						end else if (empty) begin
							// first entry goes straight to the head slot
							ram_we            = 1'b1;
							ram_waddr         = head_q;
							ram_wdata         = '{value: req.item_value, prio: req_pri};
							occ_n             = occ_q + 1'b1;
							res_n.entry_count = 5'(occ_n);
							state_n           = S_HOLD;
						end else begin
							state_n = S_SCAN;
						end
					end else begin
						if (empty) begin
							res_n.status = ST_EMPTY;
							state_n      = S_HOLD;
						end else begin
							state_n = S_DEQ;
						end
					end
				end
			end
			S_SCAN: begin
				// read data is the entry at offset pos_q - 1
				ram_we = 1'b1;
				if (ram_rdata.prio > pri_q) begin
					ram_wdata = ram_rdata;
					pos_n     = pos_m1;
					if (pos_q == IDX_W'(1)) begin
						state_n = S_PLACE;
					end
				end else begin
					occ_n   = occ_q + 1'b1;
					res_n   = '{status: ST_DONE, removed_value: '0,
						removed_priority: '0, entry_count: 5'(occ_n)};
					state_n = S_HOLD;
				end
			end
			S_PLACE: begin
				ram_we  = 1'b1;
				occ_n   = occ_q + 1'b1;
				res_n   = '{status: ST_DONE, removed_value: '0,
					removed_priority: '0, entry_count: 5'(occ_n)};
				state_n = S_HOLD;
			end
			S_DEQ: begin
				head_n  = slot_of(head_q, IDX_W'(1));
				occ_n   = occ_q - 1'b1;
				res_n   = '{status: ST_DONE, removed_value: ram_rdata.value,
					removed_priority: 8'(ram_rdata.prio), entry_count: 5'(occ_n)};
				state_n = S_HOLD;
			end
			S_HOLD: begin
				if (out_free) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			head_q  <= head_n;
			occ_q   <= occ_n;
			if (state_q == S_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pos_q <= pos_n;
		val_q <= val_n;
		pri_q <= pri_n;
		res_q <= res_n;
		if (state_q == S_HOLD && out_free) begin
			out_q <= res_q;
		end
	end

endmodule

/* sv/sipq_checker.sv */
// Port-level checker for the sorted insert priority queue, bound to the top.
// Depends on sipq_pkg and sorted_insert_priority_queue_assert.svh.
`include "sorted_insert_priority_queue_assert.svh"

module sipq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input sipq_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input sipq_pkg::rsp_t rsp
);
	import sipq_pkg::*;

	// rejected commands carry no removed entry
	`SIPQ_ASSERT_NOW(a_reject_zero, rsp_valid && rsp.status != ST_DONE, rsp.removed_value == '0 && rsp.removed_priority == '0, "rejected result carries data")

	// count never exceeds the capacity
	`SIPQ_ASSERT_NOW(a_count_bound, rsp_valid, rsp.entry_count <= 5'(DEPTH), "entry count above capacity")

	// a full reject reports a full queue, an empty reject an empty one
	`SIPQ_ASSERT_NOW(a_reject_count, rsp_valid && rsp.status != ST_DONE, (rsp.status == ST_FULL && rsp.entry_count == 5'(DEPTH)) || (rsp.status == ST_EMPTY && rsp.entry_count == '0), "reject status disagrees with count")

	// a stalled result holds
	`SIPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind sorted_insert_priority_queue sipq_checker u_sipq_checker (.*);
